[src/lruc_pkg.sv]
package lruc_pkg;

    localparam int LRUC_MAX_ENTRIES = 16;
    localparam int CFG_W            = 5;
    localparam int KEY_W            = 64;
    localparam int VAL_W            = 32;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd4;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic search;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

endpackage

[src/lruc_ram.sv]
module lruc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/lruc_ctrl.sv]
module lruc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lruc_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output lruc_pkg::t_cmd  o_cmd
);
    import lruc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_stat.out_blocked) n_state = i_in_valid ? S_SEARCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready   = 1'b0;
        o_cmd.search = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
            end
            S_COMMIT: begin
                // the next item may enter in the same cycle the current one retires
                w_in_ready   = !i_stat.out_blocked;
                o_cmd.commit = !i_stat.out_blocked;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
        o_cmd.capture = w_in_ready && i_in_valid;
    end

    assign o_in_stall = !w_in_ready;

    a_capture_then_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_SEARCH))
        else $error("captured item did not enter search");

    a_search_then_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |=> (r_state == S_COMMIT))
        else $error("search not followed by commit");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && i_stat.out_blocked) |=> (r_state == S_COMMIT))
        else $error("commit left while output blocked");

endmodule

[src/lruc_dpath.sv]
module lruc_dpath #(
    parameter int MAX_ENTRIES = lruc_pkg::LRUC_MAX_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lruc_pkg::t_cmd                i_cmd,
    output lruc_pkg::t_stat               o_stat,
    input  lruc_pkg::t_in_item            i_in_item,
    input  logic                          i_cfg_valid,
    input  logic [lruc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output lruc_pkg::t_out_item           o_out_item
);
    import lruc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_in_item         r_in;
    logic [CFG_W-1:0] r_cap;
    logic [KEY_W-1:0] r_key [MAX_ENTRIES];
    logic [IDX_W-1:0] r_age [MAX_ENTRIES];
    logic [IDX_W-1:0] n_age [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] n_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_lru_idx;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [MAX_ENTRIES-1:0] w_match;
    logic             w_hit;
    logic [IDX_W-1:0] w_hit_idx;
    logic [IDX_W-1:0] w_lru_idx;
    logic [EW-1:0]    w_eff_cap;
    logic             w_full;
    logic             w_evict;
    logic             w_new;
    logic             w_upd;
    logic [IDX_W-1:0] w_slot;
    logic [CNT_W-1:0] w_thresh;
    logic [VAL_W-1:0] w_rdata;

    // capacity zero acts as one, above the built size saturates
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = EW'(1);
        end else if (EW'(r_cap) > EW'(MAX_ENTRIES)) begin
            w_eff_cap = EW'(MAX_ENTRIES);
        end else begin
            w_eff_cap = EW'(r_cap);
        end
        w_full = EW'(r_count) >= w_eff_cap;
    end

    // tag compare lanes; keys are unique so the or-encode gives the single match
    always_comb begin
        w_hit_idx = '0;
        w_lru_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == r_in.key);
            if (w_match[i]) w_hit_idx = w_hit_idx | IDX_W'(i);
            // ages are ranks, the oldest holds count-1
            if (r_valid[i] && (CNT_W'(r_age[i]) == (r_count - CNT_W'(1)))) begin
                w_lru_idx = w_lru_idx | IDX_W'(i);
            end
        end
        w_hit = |w_match;
    end

    always_comb begin
        w_evict = !r_hit && (r_in.func == FUNC_INSERT) && w_full;
        w_new   = !r_hit && (r_in.func == FUNC_INSERT) && !w_full;
        w_upd   = r_hit || (r_in.func == FUNC_INSERT);
        // valid slots fill from zero up and never clear, so the free slot is the count
        if (r_hit) begin
            w_slot = r_hit_idx;
        end else if (w_full) begin
            w_slot = r_lru_idx;
        end else begin
            w_slot = r_count[IDX_W-1:0];
        end
        w_thresh = w_new ? r_count : CNT_W'(r_age[w_slot]);
        n_valid  = r_valid;
        n_count  = r_count;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_age[i] = r_age[i];
            if (w_upd) begin
                if (IDX_W'(i) == w_slot) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && (CNT_W'(r_age[i]) < w_thresh)) begin
                    n_age[i] = r_age[i] + IDX_W'(1);
                end
            end
        end
        if (w_new) begin
            n_valid[w_slot] = 1'b1;
            n_count         = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) r_cap <= i_cfg_data;
            if (i_cmd.commit) begin
                r_valid     <= n_valid;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    r_age[i] <= n_age[i];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_in_item;
        if (i_cmd.search) begin
            r_hit     <= w_hit;
            r_hit_idx <= w_hit_idx;
            r_lru_idx <= w_lru_idx;
        end
        if (i_cmd.commit) begin
            if (r_in.func == FUNC_INSERT) r_key[w_slot] <= r_in.key;
            r_out_item.hit         <= r_hit;
            r_out_item.read_value  <= (r_hit && (r_in.func == FUNC_LOOKUP)) ? w_rdata : '0;
            r_out_item.evicted     <= w_evict;
            r_out_item.evicted_key <= w_evict ? r_key[r_lru_idx] : '0;
        end
    end

    lruc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && (r_in.func == FUNC_INSERT)),
        .i_waddr (w_slot),
        .i_wdata (r_in.value),
        .i_re    (i_cmd.search),
        .i_raddr (w_hit_idx),
        .o_rdata (w_rdata)
    );

    assign o_stat.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out_item;

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("valid bits disagree with entry count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_ENTRIES)
        else $error("entry count above built size");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.hit && r_out_item.evicted))
        else $error("item reports both hit and eviction");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed item not presented");

endmodule

[src/lru_cache_table.sv]
// channel  | handshake                   | payload
// ---------+-----------------------------+----------------------------------
// input    | i_in_valid / o_in_stall     | i_in_item  (func, key, value)
// output   | o_out_valid / i_out_stall   | o_out_item (hit, read_value, evicted, evicted_key)
// config   | i_cfg_valid / o_cfg_ready   | i_cfg_data (capacity)
//
// an item passes the search state, for the parallel tag compare and value ram read, and then
// the commit state, to commit the age ranks, key and value and load the output register
// a new item is taken in the cycle the previous one commits
// synchronous active-low reset empties the cache and sets capacity to 4, no clearing pass
// a stalled output holds the commit cycle and the input stalls with it
module lru_cache_table #(
    parameter int MAX_ENTRIES = lruc_pkg::LRUC_MAX_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lruc_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lruc_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lruc_pkg::CFG_W-1:0] i_cfg_data
);
    import lruc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    lruc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    lruc_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_cfg_ready = 1'b1;

endmodule
